@@ src/maat_pkg.sv @@
`default_nettype none

package maat_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int MAC_W       = 48;
    localparam int COUNT_W     = 6;
    localparam int CMD_W       = 3;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_ENABLE  = 3'd3,
        CMD_DISABLE = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_t;

    // request and response beats
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [MAC_W-1:0] mac_address;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
        logic finish_scan;
        logic act;
        logic shift_end;
        logic publish;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic match;
        logic idle;
        logic skip;
        logic shift_req;
    } sts_t;

endpackage

`default_nettype wire

@@ src/maat_datapath.sv @@
`default_nettype none

module maat_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire maat_pkg::ctl_t ctl,
    input  wire maat_pkg::req_t req,
    output maat_pkg::sts_t      sts,
    output maat_pkg::rsp_t      rsp
);
    import maat_pkg::*;

    // entry memory: {enabled mark, address}
    logic [MAC_W:0]     entry_mem [MAX_ENTRIES];
    logic [MAC_W:0]     rdata_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [MAC_W-1:0]   addr_reg;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               ok_reg, ok_next;
    rsp_t               rsp_reg;

    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [MAC_W:0]     wr_data;
    logic               more;
    logic               match;

    // compare and status
    assign more  = (idx_reg < total_reg);
    assign match = pend_reg && (rdata_reg[MAC_W-1:0] == addr_reg);

    always_comb
    begin
        sts.match     = match;
        sts.idle      = !pend_reg && !more;
        sts.skip      = !(cmd_reg == CMD_LOOKUP || cmd_reg == CMD_ADD ||
                          cmd_reg == CMD_REMOVE || cmd_reg == CMD_ENABLE ||
                          cmd_reg == CMD_DISABLE);
        sts.shift_req = (cmd_reg == CMD_REMOVE) && hit_reg;
    end

    // pointer, count and memory port control
    always_comb
    begin
        total_next    = total_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        wr_ptr_next   = wr_ptr_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        ok_next       = ok_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = wr_ptr_reg;
        wr_data       = rdata_reg;

        if (ctl.load)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
            ok_next   = 1'b0;
        end

        // one read per cycle while entries remain
        if (ctl.step)
        begin
            if (more)
            begin
                rd_en         = 1'b1;
                idx_next      = idx_reg + CNT_W'(1);
                pend_next     = 1'b1;
                pend_idx_next = idx_reg[IDX_W-1:0];
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        // compaction: write the beat read last cycle one slot down
        if (ctl.shift && pend_reg)
        begin
            wr_en       = 1'b1;
            wr_addr     = wr_ptr_reg;
            wr_data     = rdata_reg;
            wr_ptr_next = wr_ptr_reg + IDX_W'(1);
        end

        if (ctl.finish_scan)
        begin
            hit_next     = match;
            hit_idx_next = pend_idx_reg;
        end

        // apply the command once the search is over
        if (ctl.act)
        begin
            unique case (cmd_reg)
                CMD_LOOKUP:
                begin
                    ok_next = hit_reg && rdata_reg[MAC_W];
                end
                CMD_ADD:
                begin
                    if (!hit_reg && (total_reg < CNT_W'(MAX_ENTRIES)))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = total_reg[IDX_W-1:0];
                        wr_data    = {1'b1, addr_reg};
                        total_next = total_reg + CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (hit_reg)
                    begin
                        idx_next    = CNT_W'({1'b0, hit_idx_reg}) + CNT_W'(1);
                        wr_ptr_next = hit_idx_reg;
                        pend_next   = 1'b0;
                        ok_next     = 1'b1;
                    end
                end
                CMD_ENABLE, CMD_DISABLE:
                begin
                    if (hit_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_reg;
                        wr_data = {(cmd_reg == CMD_ENABLE), addr_reg};
                        ok_next = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    total_next = '0;
                    ok_next    = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end

        if (ctl.shift_end)
        begin
            total_next = total_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            ok_reg    <= ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        wr_ptr_reg   <= wr_ptr_next;
        hit_idx_reg  <= hit_idx_next;
        if (ctl.load)
        begin
            cmd_reg  <= req.command;
            addr_reg <= req.mac_address;
        end
        if (ctl.publish)
        begin
            rsp_reg.ok    <= ok_reg;
            rsp_reg.count <= COUNT_W'(total_reg);
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= entry_mem[idx_reg[IDX_W-1:0]];
        end
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

@@ src/maat_controller.sv @@
`default_nettype none

module maat_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    input  wire maat_pkg::sts_t sts,
    output maat_pkg::ctl_t      ctl
);
    import maat_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   search_over;
    logic   out_free;

    assign search_over = sts.skip || sts.match || sts.idle;
    assign out_free    = !out_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (search_over)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                state_next = sts.shift_req ? ST_SHIFT : ST_DONE;
            end
            ST_SHIFT:
            begin
                if (sts.idle)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.load = req_valid;
            end
            ST_SCAN:
            begin
                ctl.step        = !sts.skip && !sts.match;
                ctl.finish_scan = search_over;
            end
            ST_ACT:
            begin
                ctl.act = 1'b1;
            end
            ST_SHIFT:
            begin
                ctl.step      = 1'b1;
                ctl.shift     = 1'b1;
                ctl.shift_end = sts.idle;
            end
            ST_DONE:
            begin
                ctl.publish = out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // output beat holding
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/mac_address_allowlist_table.sv @@
// clear and unknown commands skip the search; lookup, add, enable and disable scan the
// entries until a match or the end; remove also compacts the entries behind a hit
// throughput: one request at a time, the next taken the cycle after the response beat is
// issued; search and compaction are paced by the single read port of the entry
// memory (one entry per cycle for search and for compaction); a new request is taken while
// the previous response beat still waits. reset: entry count zero, table empty
`default_nettype none

module mac_address_allowlist_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire maat_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output maat_pkg::rsp_t      rsp
);
    import maat_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // sequencing
    maat_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // table storage and search
    maat_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
